// File: src/spq_pkg.sv
// shared types and constants of the stable priority queue
package spq_pkg;

   // number of cells in the row
   localparam int DEPTH = 16;
   // bits of the held count, wide enough to hold DEPTH itself
   localparam int CNT_W = $clog2(DEPTH + 1);

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // one held entry
   typedef struct packed {
      logic [7:0]  priority_val;
      logic [15:0] tag;
   } entry_type;

   // request payload
   typedef struct packed {
      logic        op;
      logic [7:0]  item_priority;
      logic [15:0] item_tag;
   } req_type;

   // response payload
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  removed_priority;
      logic [15:0] removed_tag;
      logic [4:0]  entry_count;
      logic [7:0]  head_priority;
      logic [15:0] head_tag;
   } rsp_type;

   // row-wide control broadcast to every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

// File: src/spq_cell.sv
// one compare-and-shift cell of the sorted row
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  spq_pkg::entry_type     new_entry,
   input  logic                   occupied,
   input  logic                   left_before,
   input  spq_pkg::entry_type     left_entry,
   input  spq_pkg::entry_type     right_entry,
   output logic                   goes_ahead,
   output spq_pkg::entry_type     entry_ff,
   output spq_pkg::entry_type     entry_in
);
   import spq_pkg::*;

   // new entry belongs ahead of this cell's entry (strictly lower priority or empty)
   assign goes_ahead = !occupied || (entry_ff.priority_val < new_entry.priority_val);

   // next entry: shift right on insert, shift left on remove
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.insert) begin
         if (left_before) begin
            entry_in = left_entry;
         end else if (goes_ahead) begin
            entry_in = new_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   // entry register
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: src/stable_priority_queue.sv
// top level of the stable priority queue: a row of sorting cells and a response register
//
//   channel  direction  handshake                payload
//   req      in         req_valid / req_stall    req_data  (spq_pkg::req_type)
//   rsp      out        rsp_valid / rsp_stall    rsp_data  (spq_pkg::rsp_type)
//
// one request per cycle while req_stall is low; its response appears in the response register in the
// cycle after acceptance, set by the single compare-and-shift step of the cell row.
// reset clears the held count and the response valid; cell contents are not reset.
// a request is stalled only while a response waits and rsp_stall is high.
module stable_priority_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             req_fire;
   cell_ctrl_type    ctrl;
   entry_type        new_entry;
   entry_type        cell_entry_ff [DEPTH];
   entry_type        cell_entry_in [DEPTH];
   entry_type        left_entry [DEPTH];
   entry_type        right_entry [DEPTH];
   logic             cell_before [DEPTH];
   logic             left_before [DEPTH];
   logic             cell_occupied [DEPTH];

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // operation decode
   assign new_entry.priority_val = req_data.item_priority;
   assign new_entry.tag          = req_data.item_tag;
   assign ctrl.insert = req_fire && (req_data.op == OP_INSERT)
                        && (count_ff < CNT_W'(DEPTH));
   assign ctrl.remove = req_fire && (req_data.op == OP_REMOVE)
                        && (count_ff != '0);

   // cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_occupied[i] = count_ff > CNT_W'(i);
      if (i == 0) begin : g_first
         assign left_before[i] = 1'b0;
         assign left_entry[i]  = '0;
      end else begin : g_inner
         assign left_before[i] = cell_before[i-1];
         assign left_entry[i]  = cell_entry_ff[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_entry[i] = '0;
      end else begin : g_body
         assign right_entry[i] = cell_entry_ff[i+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .occupied    (cell_occupied[i]),
         .left_before (left_before[i]),
         .left_entry  (left_entry[i]),
         .right_entry (right_entry[i]),
         .goes_ahead  (cell_before[i]),
         .entry_ff    (cell_entry_ff[i]),
         .entry_in    (cell_entry_in[i])
      );
   end

   // held count
   always_comb begin
      count_in = count_ff;
      priority if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // response build: removed entry from the state before the request, count and head from the state after
   always_comb begin
      rsp_data_in = '0;
      if (req_data.op == OP_INSERT) begin
         rsp_data_in.status = ctrl.insert ? ST_DONE : ST_FULL;
      end else if (ctrl.remove) begin
         rsp_data_in.status           = ST_DONE;
         rsp_data_in.removed_priority = cell_entry_ff[0].priority_val;
         rsp_data_in.removed_tag      = cell_entry_ff[0].tag;
      end else begin
         rsp_data_in.status = ST_EMPTY;
      end
      rsp_data_in.entry_count = 5'(count_in);
      if (count_in != '0) begin
         rsp_data_in.head_priority = cell_entry_in[0].priority_val;
         rsp_data_in.head_tag      = cell_entry_in[0].tag;
      end
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // count never passes the row length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("held count above depth");

   // a refused remove reports an empty queue
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.entry_count == 5'd0)
      else $error("empty status with entries held");

   // an accepted request changes the count by at most one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CNT_W'(1))
                   || (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("count moved by more than one");

   // count holds while nothing is accepted
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("count changed without a request");

   // an empty queue shows a zero head
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_count == 5'd0 && count_ff == '0
      |-> rsp_data.head_priority == 8'd0 && rsp_data.head_tag == 16'd0)
      else $error("non-zero head on empty queue");

endmodule

// File: dv/tb.sv
// testbench of the stable priority queue: scripted and random requests against a local predictor
`timescale 1ns / 100ps

module tb;
   import spq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD_CYCLES = 40;

   // one request waiting to be offered, with the idling that goes with it
   typedef struct {
      req_type req;
      int      send_idle_pct;
      int      recv_stall_pct;
      bit      wait_for_drain;
      bit      long_hold;
   } pending_req_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pending_req_type pending_reqs[$];
   pending_req_type next_req;
   rsp_type         expected_rsps[$];
   rsp_type         want;

   // predicted queue contents, slot 0 at the head
   logic [7:0]  held_priority [DEPTH];
   logic [15:0] held_tag [DEPTH];
   int          held_count = 0;

   int   cycle_count = 0;
   int   error_count = 0;
   logic req_taken = 1'b0;
   int   send_idle_now = 0;
   int   recv_stall_now = 0;
   int   long_hold_seq = 0;
   int   long_hold_seen = 0;
   int   hold_left = 0;

   stable_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // sorted insert behind equal priorities, remove from the head
   function automatic rsp_type queue_response(input req_type r);
      rsp_type res;
      int      pos;
      res = '0;
      res.status = ST_DONE;
      if (r.op == OP_INSERT) begin
         if (held_count >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < held_count && held_priority[pos] >= r.item_priority) pos++;
            for (int i = held_count; i > pos; i--) begin
               held_priority[i] = held_priority[i-1];
               held_tag[i] = held_tag[i-1];
            end
            held_priority[pos] = r.item_priority;
            held_tag[pos] = r.item_tag;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.removed_priority = held_priority[0];
            res.removed_tag = held_tag[0];
            for (int i = 0; i + 1 < held_count; i++) begin
               held_priority[i] = held_priority[i+1];
               held_tag[i] = held_tag[i+1];
            end
            held_count--;
         end
      end
      res.entry_count = held_count[4:0];
      if (held_count > 0) begin
         res.head_priority = held_priority[0];
         res.head_tag = held_tag[0];
      end
      return res;
   endfunction

   task automatic add_request(input logic op, input logic [7:0] pri, input logic [15:0] tag,
                              input int send_pct, input int recv_pct,
                              input bit drain, input bit hold);
      pending_req_type p;
      p.req.op = op;
      p.req.item_priority = pri;
      p.req.item_tag = tag;
      p.send_idle_pct = send_pct;
      p.recv_stall_pct = recv_pct;
      p.wait_for_drain = drain;
      p.long_hold = hold;
      pending_reqs.push_back(p);
   endtask

   // reset release
   always @(negedge clock) begin
      if (cycle_count >= 2) reset <= 1'b0;
   end

   // acceptance on both channels, prediction and checking
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         // check against the oldest expectation before queueing a new one
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no request waiting: %h", rsp_data);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %h, actual %h", want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.removed_priority !== want.removed_priority) begin
                  $error("removed_priority: expected %h, actual %h",
                         want.removed_priority, rsp_data.removed_priority);
                  error_count++;
               end
               if (rsp_data.removed_tag !== want.removed_tag) begin
                  $error("removed_tag: expected %h, actual %h",
                         want.removed_tag, rsp_data.removed_tag);
                  error_count++;
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d",
                         want.entry_count, rsp_data.entry_count);
                  error_count++;
               end
               if (rsp_data.head_priority !== want.head_priority) begin
                  $error("head_priority: expected %h, actual %h",
                         want.head_priority, rsp_data.head_priority);
                  error_count++;
               end
               if (rsp_data.head_tag !== want.head_tag) begin
                  $error("head_tag: expected %h, actual %h", want.head_tag, rsp_data.head_tag);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(queue_response(req_data));
            req_taken <= 1'b1;
         end else begin
            req_taken <= 1'b0;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         if (pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_reqs[0].wait_for_drain && expected_rsps.size() != 0) begin
            // pause until every outstanding response has come back
            req_valid <= 1'b0;
         end else begin
            pending_reqs[0].wait_for_drain = 1'b0;
            if ($urandom_range(99) < pending_reqs[0].send_idle_pct) begin
               req_valid <= 1'b0;
            end else begin
               next_req = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_data <= next_req.req;
               send_idle_now <= next_req.send_idle_pct;
               recv_stall_now <= next_req.recv_stall_pct;
               if (next_req.long_hold) long_hold_seq <= long_hold_seq + 1;
            end
         end
      end
   end

   // response stall, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (long_hold_seq != long_hold_seen) begin
         long_hold_seen = long_hold_seq;
         hold_left = LONG_HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_now);
      end
   end

   // stimulus and end of run
   initial begin
      int          send_pct [5];
      int          recv_pct [5];
      int          insert_bias;
      logic        op;
      logic [7:0]  pri;
      logic [15:0] tag;
      send_pct = '{0, 62, 0, 31, 0};
      recv_pct = '{0, 0, 62, 31, 0};

      // remove from empty, then the priority extremes
      add_request(OP_REMOVE, 8'hFF, 16'hFFFF, 0, 0, 0, 0);
      add_request(OP_INSERT, 8'hFF, 16'hFFFF, 0, 0, 0, 0);
      add_request(OP_INSERT, 8'h00, 16'h0000, 0, 0, 0, 0);
      // fill with ties so equal priorities must leave in arrival order
      for (int i = 0; i < 14; i++)
         add_request(OP_INSERT, (i % 2 == 0) ? 8'h80 : 8'h7F, 16'(16'h1000 + i), 0, 0, 0, 0);
      // insert into a full queue is dropped
      add_request(OP_INSERT, 8'hFF, 16'hABCD, 0, 0, 0, 0);
      for (int i = 0; i < 3; i++)
         add_request(OP_REMOVE, 8'h00, 16'h0000, 0, 0, 0, 0);

      // random phases with alternating fill and drain bias
      for (int p = 0; p < 5; p++) begin
         for (int k = 0; k < 90; k++) begin
            insert_bias = ((k / 15) % 2 == 0) ? 75 : 25;
            op = ($urandom_range(99) < insert_bias) ? OP_INSERT : OP_REMOVE;
            case ($urandom_range(3))
               0: pri = 8'($urandom_range(3) * 85);
               1: pri = 8'(120 + $urandom_range(3));
               default: pri = 8'($urandom_range(255));
            endcase
            tag = 16'($urandom_range(65535));
            add_request(op, pri, tag, send_pct[p], recv_pct[p], k == 0, p == 0 && k == 40);
         end
      end

      // wait for the last response and let the row settle
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: stable_priority_queue.f
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_queue.sv
dv/tb.sv
